### hw/rtl/line_sort_engine_assert.svh
// Assertion macros shared by the line sorter RTL.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the using module.
`ifndef LINE_SORT_ENGINE_ASSERT_SVH
`define LINE_SORT_ENGINE_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define LSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define LSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lse_pkg.sv
// Types and constants for the line sorter.
// No dependencies; used by line_sort_engine.
package lse_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_END  = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BYTE  = 3'd1,
    ST_DONE  = 3'd2,
    ST_BIG   = 3'd3,
    ST_PHASE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_LOADING  = 2'd0,
    PH_EMITTING = 2'd1,
    PH_FAILED   = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIN,
    S_SI,
    S_SK,
    S_SJ,
    S_SC,
    S_LA,
    S_LB,
    S_CK,
    S_CA,
    S_CB,
    S_E1,
    S_E2,
    S_E3
  } state_e;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] in_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
  } rsp_t;

endpackage

### hw/rtl/lse_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/line_sort_engine.sv
// Line sorter: a push, end or read word is taken only while not busy, and each result word
// is registered and appears in the cycle after the word's last step, for one cycle only.
// The end word runs an insertion sort whose length is set by the single text memory read
// port: each line compare reads both line lengths, then one character of each line at a time.
// Reset clears all control state; text and line memories hold nothing valid until written.
// Depends on lse_pkg, lse_ram and line_sort_engine_assert.svh.
`include "line_sort_engine_assert.svh"

module line_sort_engine #(
  parameter int MAX_LINES  = 512,
  parameter int BUF_BYTES  = 8192,
  parameter int LINE_LIMIT = 100
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  lse_pkg::req_t req_i,
  output logic          done_o,
  output lse_pkg::rsp_t rsp_o
);

  localparam int TAW = $clog2(BUF_BYTES);
  localparam int LAW = $clog2(MAX_LINES);
  localparam int FPW = $clog2(BUF_BYTES + 1);
  localparam int LTW = $clog2(MAX_LINES + 1);
  localparam int SW  = FPW + 9;

  lse_pkg::state_e state_q, state_d;
  lse_pkg::phase_e phase_q, phase_d;
  logic            ovf_q, ovf_d;
  logic [LTW-1:0]  line_total_q, line_total_d;
  logic [FPW-1:0]  fill_q, fill_d;
  logic [7:0]      partial_q, partial_d;
  logic [LTW-1:0]  emit_line_q, emit_line_d;
  logic [7:0]      emit_off_q, emit_off_d;
  logic [LTW-1:0]  i_q, i_d, j_q, j_d;
  logic [TAW-1:0]  key_q, key_d, cand_q, cand_d, start_q, start_d;
  logic [7:0]      la_q, la_d, lb_q, lb_d, k_q, k_d, ca_q, ca_d;
  logic            end_ctx_q, end_ctx_d;
  logic            done_q, done_d;
  lse_pkg::rsp_t   rsp_q, rsp_d;

  // Memory ports.
  logic           txt_we, tbl_we;
  logic [TAW-1:0] txt_waddr, txt_raddr, tbl_wdata, tbl_rdata;
  logic [7:0]     txt_wdata, txt_rdata;
  logic [LAW-1:0] tbl_waddr, tbl_raddr;

  lse_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_text (
    .clk_i  (clk_i),
    .we_i   (txt_we),
    .waddr_i(txt_waddr),
    .wdata_i(txt_wdata),
    .raddr_i(txt_raddr),
    .rdata_o(txt_rdata)
  );

  lse_ram #(.WIDTH(TAW), .DEPTH(MAX_LINES)) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  // Shared decode terms.
  logic           acc, is_nl, hit_limit, fin_ovf, cmp_end, cmp_diff, less, push_in_buf;
  logic [SW-1:0]  push_addr, line_end;
  logic [7:0]     cmp_n;
  lse_pkg::req_e  req;

  assign busy_o      = (state_q != lse_pkg::S_IDLE);
  assign acc         = start_i && !busy_o;
  assign req         = lse_pkg::req_e'(req_i.req_type);
  assign is_nl       = (req_i.in_byte == lse_pkg::NEWLINE);
  assign push_addr   = SW'(fill_q) + SW'(1) + SW'(partial_q);
  assign push_in_buf = (push_addr < SW'(BUF_BYTES));
  assign line_end    = SW'(fill_q) + SW'(partial_q) + SW'(1);
  assign hit_limit   = ({1'b0, partial_q} + 9'd1) >= 9'(LINE_LIMIT - 1);
  assign fin_ovf     = (line_total_q >= LTW'(MAX_LINES)) || (line_end > SW'(BUF_BYTES));
  assign cmp_n       = (la_q < lb_q) ? la_q : lb_q;
  assign cmp_end     = (k_q >= cmp_n);
  assign cmp_diff    = (ca_q != txt_rdata);
  assign less        = (state_q == lse_pkg::S_CK) ? (la_q < lb_q) : (ca_q < txt_rdata);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lse_pkg::S_IDLE: begin
        if (acc) begin
          unique case (req)
            lse_pkg::REQ_PUSH: begin
              if (phase_q == lse_pkg::PH_LOADING && !ovf_q && (is_nl || hit_limit)) begin
                state_d = lse_pkg::S_FIN;
              end
            end
            lse_pkg::REQ_END: begin
              if (phase_q == lse_pkg::PH_LOADING && !ovf_q) begin
                state_d = (partial_q != 8'd0) ? lse_pkg::S_FIN : lse_pkg::S_SI;
              end
            end
            lse_pkg::REQ_READ: begin
              if (phase_q == lse_pkg::PH_EMITTING && emit_line_q < line_total_q) begin
                state_d = lse_pkg::S_E1;
              end
            end
            default: state_d = lse_pkg::S_IDLE;
          endcase
        end
      end
      lse_pkg::S_FIN: state_d = (end_ctx_q && !fin_ovf) ? lse_pkg::S_SI : lse_pkg::S_IDLE;
      lse_pkg::S_SI:  state_d = (i_q >= line_total_q) ? lse_pkg::S_IDLE : lse_pkg::S_SK;
      lse_pkg::S_SK:  state_d = lse_pkg::S_SJ;
      lse_pkg::S_SJ:  state_d = (j_q == '0) ? lse_pkg::S_SI : lse_pkg::S_SC;
      lse_pkg::S_SC:  state_d = lse_pkg::S_LA;
      lse_pkg::S_LA:  state_d = lse_pkg::S_LB;
      lse_pkg::S_LB:  state_d = lse_pkg::S_CK;
      lse_pkg::S_CK: begin
        if (cmp_end) state_d = less ? lse_pkg::S_SJ : lse_pkg::S_SI;
        else         state_d = lse_pkg::S_CA;
      end
      lse_pkg::S_CA:  state_d = lse_pkg::S_CB;
      lse_pkg::S_CB: begin
        if (cmp_diff) state_d = less ? lse_pkg::S_SJ : lse_pkg::S_SI;
        else          state_d = lse_pkg::S_CK;
      end
      lse_pkg::S_E1:  state_d = lse_pkg::S_E2;
      lse_pkg::S_E2:  state_d = (emit_off_q < txt_rdata) ? lse_pkg::S_E3 : lse_pkg::S_IDLE;
      lse_pkg::S_E3:  state_d = lse_pkg::S_IDLE;
      default:        state_d = lse_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory controls and result words.
  always_comb begin
    phase_d      = phase_q;
    ovf_d        = ovf_q;
    line_total_d = line_total_q;
    fill_d       = fill_q;
    partial_d    = partial_q;
    emit_line_d  = emit_line_q;
    emit_off_d   = emit_off_q;
    i_d          = i_q;
    j_d          = j_q;
    key_d        = key_q;
    cand_d       = cand_q;
    start_d      = start_q;
    la_d         = la_q;
    lb_d         = lb_q;
    k_d          = k_q;
    ca_d         = ca_q;
    end_ctx_d    = end_ctx_q;
    done_d       = 1'b0;
    rsp_d        = '0;
    txt_we       = 1'b0;
    txt_waddr    = TAW'(push_addr);
    txt_wdata    = req_i.in_byte;
    txt_raddr    = key_q;
    tbl_we       = 1'b0;
    tbl_waddr    = j_q[LAW-1:0];
    tbl_wdata    = key_q;
    tbl_raddr    = emit_line_q[LAW-1:0];
    unique case (state_q)
      lse_pkg::S_IDLE: begin
        if (acc) begin
          rsp_d.status = lse_pkg::ST_PHASE;
          unique case (req)
            lse_pkg::REQ_PUSH: begin
              if (phase_q == lse_pkg::PH_LOADING) begin
                if (ovf_q) begin
                  done_d       = 1'b1;
                  rsp_d.status = lse_pkg::ST_BIG;
                end else if (is_nl) begin
                  end_ctx_d = 1'b0;
                end else begin
                  txt_we    = push_in_buf;
                  partial_d = partial_q + 8'd1;
                  end_ctx_d = 1'b0;
                  if (!hit_limit) begin
                    done_d       = 1'b1;
                    rsp_d.status = lse_pkg::ST_OK;
                  end
                end
              end else begin
                done_d = 1'b1;
              end
            end
            lse_pkg::REQ_END: begin
              if (phase_q == lse_pkg::PH_LOADING) begin
                if (ovf_q) begin
                  phase_d      = lse_pkg::PH_FAILED;
                  done_d       = 1'b1;
                  rsp_d.status = lse_pkg::ST_BIG;
                end else begin
                  end_ctx_d = 1'b1;
                  i_d       = LTW'(1);
                end
              end else begin
                done_d = 1'b1;
              end
            end
            lse_pkg::REQ_READ: begin
              if (phase_q == lse_pkg::PH_FAILED) begin
                done_d       = 1'b1;
                rsp_d.status = lse_pkg::ST_BIG;
              end else if (phase_q == lse_pkg::PH_EMITTING) begin
                if (emit_line_q >= line_total_q) begin
                  done_d       = 1'b1;
                  rsp_d.status = lse_pkg::ST_DONE;
                end
              end else begin
                done_d = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      // Close the pending line: length byte, table entry, or the overflow flag.
      lse_pkg::S_FIN: begin
        partial_d = 8'd0;
        if (fin_ovf) begin
          ovf_d = 1'b1;
        end else begin
          txt_we       = 1'b1;
          txt_waddr    = TAW'(fill_q);
          txt_wdata    = partial_q;
          tbl_we       = 1'b1;
          tbl_waddr    = line_total_q[LAW-1:0];
          tbl_wdata    = TAW'(fill_q);
          line_total_d = line_total_q + LTW'(1);
          fill_d       = FPW'(line_end);
        end
        if (!end_ctx_q) begin
          done_d       = 1'b1;
          rsp_d.status = fin_ovf ? lse_pkg::ST_BIG : lse_pkg::ST_OK;
        end else if (fin_ovf) begin
          phase_d      = lse_pkg::PH_FAILED;
          done_d       = 1'b1;
          rsp_d.status = lse_pkg::ST_BIG;
        end
      end
      // Insertion sort outer step: fetch the key or finish.
      lse_pkg::S_SI: begin
        tbl_raddr = i_q[LAW-1:0];
        if (i_q >= line_total_q) begin
          phase_d      = lse_pkg::PH_EMITTING;
          emit_line_d  = '0;
          emit_off_d   = 8'd0;
          done_d       = 1'b1;
          rsp_d.status = lse_pkg::ST_OK;
        end
      end
      lse_pkg::S_SK: begin
        key_d = tbl_rdata;
        j_d   = i_q;
      end
      // Inner step: place the key at the front, or fetch the entry before it.
      lse_pkg::S_SJ: begin
        tbl_raddr = LAW'(j_q - LTW'(1));
        if (j_q == '0) begin
          tbl_we = 1'b1;
          i_d    = i_q + LTW'(1);
        end
      end
      lse_pkg::S_SC: begin
        cand_d    = tbl_rdata;
        txt_raddr = key_q;
      end
      lse_pkg::S_LA: begin
        la_d      = txt_rdata;
        txt_raddr = cand_q;
      end
      lse_pkg::S_LB: begin
        lb_d = txt_rdata;
        k_d  = 8'd0;
      end
      // Compare loop: one character of each line per pass through S_CK, S_CA and S_CB.
      lse_pkg::S_CK: begin
        txt_raddr = key_q + TAW'(1) + TAW'(k_q);
        if (cmp_end) begin
          tbl_we = 1'b1;
          if (less) begin
            tbl_wdata = cand_q;
            j_d       = j_q - LTW'(1);
          end else begin
            i_d = i_q + LTW'(1);
          end
        end
      end
      lse_pkg::S_CA: begin
        ca_d      = txt_rdata;
        txt_raddr = cand_q + TAW'(1) + TAW'(k_q);
      end
      lse_pkg::S_CB: begin
        if (cmp_diff) begin
          tbl_we = 1'b1;
          if (less) begin
            tbl_wdata = cand_q;
            j_d       = j_q - LTW'(1);
          end else begin
            i_d = i_q + LTW'(1);
          end
        end else begin
          k_d = k_q + 8'd1;
        end
      end
      // Output read: line start, then length, then the character, or a newline at the end of the line.
      lse_pkg::S_E1: begin
        start_d   = tbl_rdata;
        txt_raddr = tbl_rdata;
      end
      lse_pkg::S_E2: begin
        txt_raddr = start_q + TAW'(1) + TAW'(emit_off_q);
        if (emit_off_q >= txt_rdata) begin
          done_d         = 1'b1;
          rsp_d.status   = lse_pkg::ST_BYTE;
          rsp_d.out_byte = lse_pkg::NEWLINE;
          emit_line_d    = emit_line_q + LTW'(1);
          emit_off_d     = 8'd0;
        end
      end
      lse_pkg::S_E3: begin
        done_d         = 1'b1;
        rsp_d.status   = lse_pkg::ST_BYTE;
        rsp_d.out_byte = txt_rdata;
        emit_off_d     = emit_off_q + 8'd1;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lse_pkg::S_IDLE;
      phase_q      <= lse_pkg::PH_LOADING;
      ovf_q        <= 1'b0;
      line_total_q <= '0;
      fill_q       <= '0;
      partial_q    <= 8'd0;
      emit_line_q  <= '0;
      emit_off_q   <= 8'd0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      ovf_q        <= ovf_d;
      line_total_q <= line_total_d;
      fill_q       <= fill_d;
      partial_q    <= partial_d;
      emit_line_q  <= emit_line_d;
      emit_off_q   <= emit_off_d;
      done_q       <= done_d;
    end
  end

  // Working registers of the sort and read sequences.
  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    j_q       <= j_d;
    key_q     <= key_d;
    cand_q    <= cand_d;
    start_q   <= start_d;
    la_q      <= la_d;
    lb_q      <= lb_d;
    k_q       <= k_d;
    ca_q      <= ca_d;
    end_ctx_q <= end_ctx_d;
    rsp_q     <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `LSE_ASSERT_NOW(a_word_when_idle, done_q, state_q == lse_pkg::S_IDLE, "result word while busy")
  `LSE_ASSERT_NOW(a_byte_zero, done_q && rsp_q.status != lse_pkg::ST_BYTE, rsp_q.out_byte == 8'd0, "nonzero byte without delivery")
  `LSE_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FPW'(BUF_BYTES), "fill point past buffer")
  `LSE_ASSERT_NOW(a_lines_bound, 1'b1, line_total_q <= LTW'(MAX_LINES), "too many lines stored")
  `LSE_ASSERT_NEXT(a_accept_progress, start_i && !busy_o, done_q || busy_o, "accepted word dropped")

endmodule
